// File: rtl/tdca_pkg.sv
package tdca_pkg;

  localparam int unsigned TIME_W    = 17;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned MIN_IDX_W = 11;  // whole minutes in a day, below 1440

  localparam logic [TIME_W:0]   DAY_SECONDS    = 18'd86400;
  localparam logic [TIME_W-1:0] MINUTE_SECONDS = 17'd60;
  localparam logic [TIME_W-1:0] ALARM_RESET    = 17'd120;
  localparam logic [4:0]        HALF_DAY_HOURS = 5'd12;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TIME   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 8'd1;

  // input kinds carried in tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // reciprocal constants: floor(t * RECIP / 2**SHIFT) == t / 60 over the used range
  localparam logic [17:0] RECIP60_T   = 18'd139811;  // t < 2**17, shift 23
  localparam int unsigned SHIFT60_T   = 23;
  localparam logic [10:0] RECIP60_MIN = 11'd1093;    // q < 1440, shift 16
  localparam int unsigned SHIFT60_MIN = 16;

  // display time captured by the state stage
  typedef struct packed {
    logic [TIME_W-1:0] held_time;
    logic              buzzer;
    logic              refreshed;
  } tdca_hold_t;

  // after the first reciprocal multiply
  typedef struct packed {
    logic [TIME_W-1:0]    held_time;
    logic [MIN_IDX_W-1:0] total_min;
    logic                 buzzer;
    logic                 refreshed;
  } tdca_div1_t;

  // after the second reciprocal multiply
  typedef struct packed {
    logic [4:0]           hour;
    logic [MIN_IDX_W-1:0] total_min;
    logic [5:0]           second;
    logic                 buzzer;
    logic                 refreshed;
  } tdca_div2_t;

endpackage

// File: rtl/tdca_state.sv
module tdca_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [tdca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tdca_pkg::TIME_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [tdca_pkg::TIME_W-1:0]   set_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tdca_pkg::tdca_hold_t          out_data
);
  import tdca_pkg::*;

  logic [TIME_W-1:0] alarm_time;
  logic              alarm_enable;
  logic [TIME_W-1:0] seconds_count, seconds_count_next;
  logic [TIME_W-1:0] next_mark, next_mark_next;
  logic [TIME_W-1:0] held_time, held_time_next;
  logic              buzzer_on, buzzer_on_next;
  logic              refresh;
  logic [TIME_W:0]   tick_sum;
  logic [TIME_W-1:0] refresh_time;
  logic              accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick_sum = {1'b0, seconds_count} + {{TIME_W{1'b0}}, 1'b1};

  always_comb begin
    seconds_count_next = seconds_count;
    refresh            = 1'b0;
    refresh_time       = seconds_count;
    if (opcode == OP_LOAD) begin
      seconds_count_next = set_value;
    end else if (tick_sum >= DAY_SECONDS) begin
      // midnight wrap
      seconds_count_next = '0;
      refresh_time       = '0;
      refresh            = 1'b1;
    end else begin
      seconds_count_next = tick_sum[TIME_W-1:0];
      refresh_time       = tick_sum[TIME_W-1:0];
      refresh            = (tick_sum >= {1'b0, next_mark});
    end
  end

  always_comb begin
    next_mark_next = next_mark;
    held_time_next = held_time;
    buzzer_on_next = buzzer_on;
    if (refresh) begin
      next_mark_next = refresh_time + MINUTE_SECONDS;
      held_time_next = refresh_time;
      buzzer_on_next = alarm_enable && (alarm_time == refresh_time);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_time   <= ALARM_RESET;
      alarm_enable <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ALARM_TIME) begin
        alarm_time <= cfg_data;
      end else if (cfg_index == REG_ALARM_ENABLE) begin
        alarm_enable <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count <= '0;
      next_mark     <= MINUTE_SECONDS;
      held_time     <= '0;
      buzzer_on     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        seconds_count <= seconds_count_next;
        next_mark     <= next_mark_next;
        held_time     <= held_time_next;
        buzzer_on     <= buzzer_on_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.held_time <= held_time_next;
      out_data.buzzer    <= buzzer_on_next;
      out_data.refreshed <= refresh;
    end
  end

endmodule

// File: rtl/tdca_split.sv
module tdca_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tdca_pkg::tdca_hold_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tdca_pkg::tdca_div2_t out_data
);
  import tdca_pkg::*;

  localparam int unsigned P1_W = TIME_W + 18;
  localparam int unsigned P2_W = 2 * MIN_IDX_W;

  tdca_div1_t          s1;
  logic                s1_valid;
  logic                s1_ready;
  logic [P1_W-1:0]     prod_min;
  logic [P2_W-1:0]     prod_hour;
  logic [TIME_W-1:0]   min_secs;

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  // t / 60
  assign prod_min = P1_W'(in_data.held_time) * P1_W'(RECIP60_T);
  // (t / 60) / 60, and t mod 60
  assign prod_hour = P2_W'(s1.total_min) * P2_W'(RECIP60_MIN);
  assign min_secs  = TIME_W'(s1.total_min) * MINUTE_SECONDS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid  <= in_valid;
      if (s1_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1.held_time <= in_data.held_time;
      s1.total_min <= prod_min[SHIFT60_T +: MIN_IDX_W];
      s1.buzzer    <= in_data.buzzer;
      s1.refreshed <= in_data.refreshed;
    end
    if (s1_valid && s1_ready) begin
      out_data.hour      <= prod_hour[SHIFT60_MIN +: 5];
      out_data.total_min <= s1.total_min;
      out_data.second    <= 6'(s1.held_time - min_secs);
      out_data.buzzer    <= s1.buzzer;
      out_data.refreshed <= s1.refreshed;
    end
  end

endmodule

// File: rtl/tdca_out.sv
module tdca_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tdca_pkg::tdca_div2_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [23:0]          out_data
);
  import tdca_pkg::*;

  logic [MIN_IDX_W-1:0] hour_mins;
  logic [5:0]           minute;
  logic                 pm;
  logic [3:0]           hour_12;

  assign in_ready  = !out_valid || out_ready;
  assign hour_mins = MIN_IDX_W'(in_data.hour) * MIN_IDX_W'(MINUTE_SECONDS);
  assign minute    = 6'(in_data.total_min - hour_mins);
  assign pm        = (in_data.hour >= HALF_DAY_HOURS);
  assign hour_12   = pm ? 4'(in_data.hour - HALF_DAY_HOURS) : 4'(in_data.hour);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= {in_data.refreshed, in_data.buzzer, in_data.second, minute,
                   pm, hour_12, in_data.hour};
    end
  end

endmodule

// File: rtl/time_of_day_clock_alarm_top.sv
// Time-of-day clock with alarm.
// Input stream: each transfer is one item. tuser selects the kind: a one-second
// tick, or a load of the time of day from tdata. Every item yields exactly one
// output transfer carrying the latched display (hours in 24 and 12 hour form,
// pm flag, minutes, seconds), the buzzer and a flag saying this item refreshed.
// Configuration channel: alarm time (index 0) and alarm enable (index 1), one
// write per transfer; unknown indexes are dropped. Write only while idle.
// Throughput: one item per cycle while the output is not stalled. Four registers
// in a row lie between the input transfer and m_axis_tvalid: the state stage
// (loaded at the transfer edge itself), two reciprocal-multiply stages for the
// /60 splits and the formatting register.
// Reset: time 0, display 00:00:00, next refresh at 60 s, buzzer off, alarm at
// 120 s and disabled. No clearing pass; items are taken right after reset.
// Stall: each stage holds its result while downstream is stalled, and
// s_axis_tready drops only once every stage is full, so no item is lost.
module time_of_day_clock_alarm_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tdca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tdca_pkg::TIME_W-1:0]    cfg_data,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // set_value[16:0], zero pad
  input  logic                           s_axis_tuser,  // opcode
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata   // hour_24[4:0], hour_12[8:5],
                                                        // pm_flag[9], minute_out[15:10],
                                                        // second_out[21:16], buzzer[22],
                                                        // refreshed[23]
);
  import tdca_pkg::*;

  tdca_hold_t hold_data;
  logic       hold_valid;
  logic       hold_ready;
  tdca_div2_t div_data;
  logic       div_valid;
  logic       div_ready;

  // config regs are plain flops, a write always completes
  assign cfg_ready = 1'b1;

  // state update and refresh decision
  tdca_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .opcode    (s_axis_tuser),
    .set_value (s_axis_tdata[TIME_W-1:0]),
    .out_valid (hold_valid),
    .out_ready (hold_ready),
    .out_data  (hold_data)
  );

  // seconds -> hours, total minutes, seconds
  tdca_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hold_valid),
    .in_ready  (hold_ready),
    .in_data   (hold_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // minute, 12 hour form and result register
  tdca_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
